// ===== rtl/recent_search_lru_list_defines.svh =====
// Assertion helpers used by the top-level RTL
`ifndef RECENT_SEARCH_LRU_LIST_DEFINES_SVH
`define RECENT_SEARCH_LRU_LIST_DEFINES_SVH

// same-cycle implication
`define RSL_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define RSL_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/rsl_pkg.sv =====
package rsl_pkg;

	localparam int MAX_ENTRIES = 8;
	localparam int KEY_BITS    = 32;
	localparam int IO_KEY_BITS = 32;
	localparam int CAP_BITS    = 4;
	localparam int POS_BITS    = 3;
	localparam int IDX_BITS    = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CNT_BITS    = IDX_BITS + 1;

	typedef logic [KEY_BITS-1:0] key_t;
	typedef logic [CNT_BITS-1:0] cnt_t;
	typedef logic [IDX_BITS-1:0] idx_t;

	typedef enum logic [2:0] {
		OP_HOLD,
		OP_MOVE,
		OP_EVICT,
		OP_APPEND,
		OP_ROTATE
	} cell_op_t;

	typedef struct packed {
		cell_op_t op;
		key_t     key;
		key_t     head;
		cnt_t     count;
	} cell_ctrl_t;

endpackage

// ===== rtl/rsl_cell.sv =====
module rsl_cell
	import rsl_pkg::*;
(
	input  logic       clk,
	input  idx_t       cell_idx,
	input  cell_ctrl_t ctrl,
	input  key_t       nb_key,
	input  logic       hit_in,
	output key_t       key,
	output logic       hit_out
);

	key_t key_q;
	cnt_t idx_c;
	cnt_t idx_n;
	logic valid;
	logic match;
	logic in_hit;

	assign idx_c   = CNT_BITS'(cell_idx);
	assign idx_n   = idx_c + cnt_t'(1);
	assign valid   = idx_c < ctrl.count;
	assign match   = valid && (key_q == ctrl.key);
	assign in_hit  = hit_in | match;
	assign hit_out = in_hit;
	assign key     = key_q;

	always_ff @(posedge clk) begin
		case (ctrl.op)
			OP_MOVE: begin
				if (in_hit && idx_n < ctrl.count) begin
					key_q <= nb_key;
				end else if (in_hit && idx_n == ctrl.count) begin
					key_q <= ctrl.key;
				end
			end
			OP_EVICT: begin
				key_q <= nb_key;
			end
			OP_APPEND: begin
				if (idx_c == ctrl.count) begin
					key_q <= ctrl.key;
				end
			end
			OP_ROTATE: begin
				if (idx_n < ctrl.count) begin
					key_q <= nb_key;
				end else if (idx_n == ctrl.count) begin
					key_q <= ctrl.head;
				end
			end
			default: begin
				key_q <= key_q;
			end
		endcase
	end

endmodule

// ===== rtl/recent_search_lru_list.sv =====
// After start is taken, an absent key first evicts the oldest entry while the list is full
// (more than once only after the capacity is lowered below the count); then the list is
// emitted, one word per cycle, n words for an n-entry list.
// A new key is taken only when busy is low, once the rotation for the last key is done.
// Reset: list empties, capacity returns to 8; stored keys are not cleared.
// The receiver cannot stall: each word is on the ports for one cycle only.
module recent_search_lru_list
	import rsl_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  logic [IO_KEY_BITS-1:0] search_key,
	input  logic                   cfg_we,
	input  logic [CAP_BITS-1:0]    cfg_wdata,
	output logic                   result_valid,
	output logic [IO_KEY_BITS-1:0] listed_key,
	output logic [POS_BITS-1:0]    list_position,
	output logic                   last_of_list
);

`include "recent_search_lru_list_defines.svh"

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_MATCH = 3'b010,
		ST_EMIT  = 3'b100
	} state_t;

	state_t              state_q;
	logic [CAP_BITS-1:0] cap_q;
	cnt_t                count_q;
	idx_t                emit_idx_q;
	key_t                key_q;
	logic                out_valid_q;
	logic [IO_KEY_BITS-1:0] out_key_q;
	logic [POS_BITS-1:0] out_pos_q;
	logic                out_last_q;

	cell_ctrl_t          ctrl;
	key_t                cell_key [MAX_ENTRIES];
	key_t                nb_key   [MAX_ENTRIES];
	logic [MAX_ENTRIES:0] hit;
	cnt_t                eff_cap;
	logic                found;
	logic                full;
	logic                emit_last;

	always_comb begin
		if (cap_q == '0) begin
			eff_cap = cnt_t'(1);
		end else if (32'(cap_q) > 32'(MAX_ENTRIES)) begin
			eff_cap = CNT_BITS'(MAX_ENTRIES);
		end else begin
			eff_cap = CNT_BITS'(cap_q);
		end
	end

	assign found     = hit[MAX_ENTRIES];
	assign full      = count_q >= eff_cap;
	assign emit_last = (CNT_BITS'(emit_idx_q) + cnt_t'(1)) == count_q;
	assign busy      = state_q != ST_IDLE;

	always_comb begin
		ctrl.key   = key_q;
		ctrl.head  = cell_key[0];
		ctrl.count = count_q;
		ctrl.op    = OP_HOLD;
		unique case (state_q)
			ST_MATCH: begin
				if (found) begin
					ctrl.op = OP_MOVE;
				end else if (full) begin
					ctrl.op = OP_EVICT;
				end else begin
					ctrl.op = OP_APPEND;
				end
			end
			ST_EMIT: ctrl.op = OP_ROTATE;
			default: ctrl.op = OP_HOLD;
		endcase
	end

	assign hit[0] = 1'b0;

	for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
		if (i == MAX_ENTRIES - 1) begin : g_end
			assign nb_key[i] = '0;
		end else begin : g_mid
			assign nb_key[i] = cell_key[i+1];
		end

		rsl_cell u_cell (
			.clk      (clk),
			.cell_idx (IDX_BITS'(i)),
			.ctrl     (ctrl),
			.nb_key   (nb_key[i]),
			.hit_in   (hit[i]),
			.key      (cell_key[i]),
			.hit_out  (hit[i+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cap_q       <= CAP_BITS'(MAX_ENTRIES);
			count_q     <= '0;
			emit_idx_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= 1'b0;
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_MATCH;
					end
				end
				ST_MATCH: begin
					if (found) begin
						state_q <= ST_EMIT;
					end else if (full) begin
						count_q <= count_q - cnt_t'(1);
					end else begin
						count_q <= count_q + cnt_t'(1);
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					out_valid_q <= 1'b1;
					if (emit_last) begin
						emit_idx_q <= '0;
						state_q    <= ST_IDLE;
					end else begin
						emit_idx_q <= emit_idx_q + idx_t'(1);
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			key_q <= KEY_BITS'(search_key);
		end
		if (state_q == ST_EMIT) begin
			out_key_q  <= IO_KEY_BITS'(cell_key[0]);
			out_pos_q  <= POS_BITS'(emit_idx_q);
			out_last_q <= emit_last;
		end
	end

	assign result_valid  = out_valid_q;
	assign listed_key    = out_key_q;
	assign list_position = out_pos_q;
	assign last_of_list  = out_last_q;

	`RSL_ASSERT_NEXT(a_accept_busy, start && !busy, busy && state_q == ST_MATCH, "accepted word did not start a search")
	`RSL_ASSERT_NEXT(a_append_count, state_q == ST_MATCH && !found && !full, count_q == $past(count_q) + cnt_t'(1), "append did not grow the list")
	`RSL_ASSERT_NOW(a_last_pos, result_valid && last_of_list, list_position == POS_BITS'(count_q - cnt_t'(1)), "last word not at list end")
	`RSL_ASSERT_NEXT(a_burst, result_valid && !last_of_list, result_valid, "listing broke off early")

endmodule

// ===== tb/recent_search_lru_list_tb.sv =====
module recent_search_lru_list_tb
	import rsl_pkg::*;
;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STALL_LIMIT = 4000;
	localparam int WIND_DOWN   = 2 + 2 * MAX_ENTRIES + 4;
	localparam int N_REPORTED  = 10;

	typedef struct {
		logic [IO_KEY_BITS-1:0] key;
		logic [POS_BITS-1:0]    pos;
		logic                   is_last;
	} listing_word_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   start = 1'b0;
	logic                   busy;
	logic [IO_KEY_BITS-1:0] search_key = '0;
	logic                   cfg_we = 1'b0;
	logic [CAP_BITS-1:0]    cfg_wdata = '0;
	logic                   result_valid;
	logic [IO_KEY_BITS-1:0] listed_key;
	logic [POS_BITS-1:0]    list_position;
	logic                   last_of_list;

	// predictor state
	key_t                stored_keys [MAX_ENTRIES];
	int                  stored_count = 0;
	logic [CAP_BITS-1:0] list_cap = 4'd8;

	logic [IO_KEY_BITS-1:0] key_backlog [$];
	listing_word_t          listing_words_due [$];
	int                     idle_pct = 16;
	int                     mismatch_count = 0;
	int                     stall_cycles = 0;

	recent_search_lru_list u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.search_key   (search_key),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.result_valid (result_valid),
		.listed_key   (listed_key),
		.list_position(list_position),
		.last_of_list (last_of_list)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic int eff_capacity(input logic [CAP_BITS-1:0] c);
		if (c < 1) return 1;
		if (c > MAX_ENTRIES) return MAX_ENTRIES;
		return int'(c);
	endfunction

	task automatic predict_listing(input logic [IO_KEY_BITS-1:0] in_key);
		key_t          k;
		int            n;
		int            cap;
		int            hit;
		int            drop;
		bit            found;
		listing_word_t w;
		k = key_t'(in_key);
		n = stored_count;
		cap = eff_capacity(list_cap);
		found = 1'b0;
		hit = 0;
		for (int i = 0; i < n; i++) begin
			if (!found && stored_keys[i] == k) begin
				found = 1'b1;
				hit = i;
			end
		end
		if (found) begin
			for (int i = hit; i + 1 < n; i++)
				stored_keys[i] = stored_keys[i + 1];
			stored_keys[n - 1] = k;
		end else begin
			// also trims the list when the capacity was lowered below the count
			if (n >= cap) begin
				drop = n - cap + 1;
				for (int i = 0; i + drop < n; i++)
					stored_keys[i] = stored_keys[i + drop];
				n -= drop;
			end
			stored_keys[n] = k;
			n++;
		end
		stored_count = n;
		for (int i = 0; i < n; i++) begin
			w.key = stored_keys[i][IO_KEY_BITS-1:0];
			w.pos = POS_BITS'(i);
			w.is_last = (i + 1 == n);
			listing_words_due = {listing_words_due, w};
		end
	endtask

	function automatic void note_mismatch(input string msg);
		mismatch_count++;
		if (mismatch_count <= N_REPORTED)
			$display("[%0t] mismatch: %s", $realtime, msg);
	endfunction

	// driver
	always @(posedge clk) begin
		if (start && !busy)
			predict_listing(search_key);
		if (!start || !busy) begin
			if (arst_n && key_backlog.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
				start <= 1'b1;
				search_key <= key_backlog.pop_front();
			end else begin
				start <= 1'b0;
			end
		end
	end

	// monitor
	always @(posedge clk) begin : monitor
		listing_word_t want;
		if (arst_n && result_valid) begin
			if (listing_words_due.size() == 0) begin
				note_mismatch($sformatf("unexpected word key=%h pos=%0d last=%b",
					listed_key, list_position, last_of_list));
			end else begin
				want = listing_words_due.pop_front();
				if (listed_key !== want.key || list_position !== want.pos ||
					last_of_list !== want.is_last)
					note_mismatch($sformatf(
						"expected key=%h pos=%0d last=%b, got key=%h pos=%0d last=%b",
						want.key, want.pos, want.is_last,
						listed_key, list_position, last_of_list));
			end
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || result_valid)
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
	end

	initial begin
		wait (stall_cycles >= STALL_LIMIT);
		$display("FAILURE");
		$finish;
	end

	task automatic wait_quiet();
		while (key_backlog.size() != 0 || start || listing_words_due.size() != 0)
			@(posedge clk);
		while (busy)
			@(posedge clk);
		repeat (WIND_DOWN) @(posedge clk);
	endtask

	task automatic write_capacity(input logic [CAP_BITS-1:0] v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		list_cap = v;
	endtask

	task automatic run_directed(input logic [CAP_BITS-1:0] cap,
		input logic [IO_KEY_BITS-1:0] keys [$]);
		write_capacity(cap);
		@(negedge clk);
		foreach (keys[i])
			key_backlog = {key_backlog, keys[i]};
		wait_quiet();
	endtask

	task automatic run_random(input logic [CAP_BITS-1:0] cap, input int n_items,
		input int pct);
		logic [IO_KEY_BITS-1:0] pool [$];
		int                     pool_size;
		write_capacity(cap);
		idle_pct = pct;
		// small pool so that hits, moves and evictions all occur
		pool_size = eff_capacity(cap) + $urandom_range(0, 4);
		for (int i = 0; i < pool_size; i++)
			pool = {pool, $urandom};
		@(negedge clk);
		for (int i = 0; i < n_items; i++) begin
			if ($urandom_range(0, 99) < 80)
				key_backlog = {key_backlog, pool[$urandom_range(0, pool_size - 1)]};
			else
				key_backlog = {key_backlog, $urandom};
		end
		wait_quiet();
	endtask

	initial begin
		logic [CAP_BITS-1:0] caps [$];
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// fill, evict, hit at head, middle and tail, extremes of the key
		run_directed(4'd8, '{32'h0000_0000, 32'hFFFF_FFFF, 32'h1, 32'h2, 32'h8000_0000,
			32'h3, 32'h4, 32'h5, 32'h6, 32'hFFFF_FFFF, 32'h2, 32'h2, 32'h0000_0000,
			32'h0000_0001});
		// capacity below count: a hit only moves, an absent key trims
		run_directed(4'd3, '{32'h5, 32'h7, 32'h1234_5678, 32'h7});
		// zero capacity acts as one
		run_directed(4'd0, '{32'h7, 32'h9, 32'h9});
		// above the maximum acts as the maximum
		run_directed(4'd15, '{32'hA5A5_A5A5, 32'h5A5A_5A5A, 32'h9});

		caps = '{4'd1, 4'd8, 4'd15, 4'd0, 4'd5, 4'd2, 4'd9, 4'd3, 4'd7, 4'd4, 4'd6,
			4'd12, 4'd8};
		foreach (caps[i])
			run_random(caps[i], 31, (i == 6) ? 0 : 16);

		wait_quiet();
		if (mismatch_count == 0 && listing_words_due.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/rsl_pkg.sv
rtl/rsl_cell.sv
rtl/recent_search_lru_list.sv
tb/recent_search_lru_list_tb.sv
